// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, constants and glyph table for the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int unsigned BufferChars = 5;
   localparam int unsigned Digits      = 4;

   localparam logic       OP_TICK  = 1'b0;
   localparam logic       OP_WRITE = 1'b1;

   localparam logic       CSR_SCAN_PERIOD = 1'b0;
   localparam logic       CSR_BLANK_TIME  = 1'b1;

   localparam logic [7:0]  DOT_CODE     = 8'd46;
   localparam logic [7:0]  SEG_POINT    = 8'h80;
   localparam logic [15:0] SCAN_PERIOD_RESET = 16'd16;
   localparam logic [15:0] BLANK_TIME_RESET  = 16'd2;

   typedef logic [BufferChars-1:0][7:0] char_buffer_type;

   typedef struct packed {
      logic       op;
      logic [2:0] position;
      logic [7:0] character;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] digit_enable;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] digit_enable;
   } light_type;

   function automatic logic [7:0] glyph_of(input logic [7:0] c);
      logic [7:0] g;
      case (c)
         8'h2E:   g = 8'h80; // '.'
         8'h30:   g = 8'h3F;
         8'h31:   g = 8'h06;
         8'h32:   g = 8'h5B;
         8'h33:   g = 8'h4F;
         8'h34:   g = 8'h66;
         8'h35:   g = 8'h6D;
         8'h36:   g = 8'h7D;
         8'h37:   g = 8'h07;
         8'h38:   g = 8'h7F;
         8'h39:   g = 8'h6F;
         8'h41:   g = 8'h77; // A
         8'h43:   g = 8'h39; // C
         8'h45:   g = 8'h79; // E
         8'h4C:   g = 8'h38; // L
         8'h4F:   g = 8'h3F; // O
         8'h61:   g = 8'h5F; // a
         8'h62:   g = 8'h7C; // b
         8'h63:   g = 8'h58; // c
         8'h64:   g = 8'h5E; // d
         8'h66:   g = 8'h71; // f
         8'h68:   g = 8'h74; // h
         8'h6E:   g = 8'h54; // n
         8'h6F:   g = 8'h5C; // o
         8'h72:   g = 8'h50; // r
         8'h74:   g = 8'h78; // t
         default: g = 8'h00;
      endcase
      return g;
   endfunction

endpackage

// ===== rtl/ssd_digit_mux.sv =====
// ----------------------------------------------------------------------------
// ssd_digit_mux
// Selects the glyph for the current digit, merging the first dot in
// positions 0..3 into the point of the preceding digit.
// ----------------------------------------------------------------------------
module ssd_digit_mux (
   input  ssd_pkg::char_buffer_type char_buffer,
   input  logic [1:0]               digit_index,
   output ssd_pkg::light_type       light
);

   logic       dot_found;
   logic [1:0] dot_pos;
   logic [2:0] src;
   logic [7:0] seg;

   always_comb begin
      dot_found = 1'b0;
      dot_pos   = 2'd0;
      for (int i = ssd_pkg::Digits - 1; i >= 0; i--) begin
         if (char_buffer[i] == ssd_pkg::DOT_CODE) begin
            dot_found = 1'b1;
            dot_pos   = 2'(i);
         end
      end
   end

   assign src = {1'b0, digit_index} + {2'b00, dot_found && (digit_index >= dot_pos)};

   always_comb begin
      seg = ssd_pkg::glyph_of(char_buffer[src]);
      if (dot_found && (dot_pos != 2'd0) && (digit_index == dot_pos - 2'd1)) begin
         seg = seg | ssd_pkg::SEG_POINT;
      end
      light.segments     = seg;
      light.digit_enable = 4'b0001 << digit_index;
   end

endmodule

// ===== rtl/seven_segment_scan_driver.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed four-digit seven-segment driver fed from a text buffer.
// ----------------------------------------------------------------------------
// The result is valid in the cycle after a transaction is accepted.
// Throughput: one transaction per cycle while the result is not stalled; the result register alone sets it.
// A stalled result holds req_stall high until it is taken.
// Reset: synchronous; buffer, counter, digit index and latches clear,
// scan_period loads 16 and blank_time loads 2.
module seven_segment_scan_driver (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ssd_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [15:0]              csr_wdata
);

   ssd_pkg::char_buffer_type buffer_ff, buffer_in;
   logic [15:0] counter_ff, counter_in;
   logic [1:0]  index_ff, index_in;
   logic [7:0]  seg_ff, seg_in;
   logic [3:0]  en_ff, en_in;
   logic [15:0] period_ff, blank_ff;
   logic        valid_ff, valid_in;
   ssd_pkg::rsp_payload_type payload_ff, payload_in;

   logic               accept;
   logic [15:0]        count;
   ssd_pkg::light_type light;

   ssd_digit_mux u_mux (
      .char_buffer (buffer_ff),
      .digit_index (index_ff),
      .light       (light)
   );

   assign req_stall = reset | (valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign count     = (counter_ff == 16'd0) ? period_ff : counter_ff;

   always_comb begin
      buffer_in  = buffer_ff;
      counter_in = counter_ff;
      index_in   = index_ff;
      seg_in     = seg_ff;
      en_in      = en_ff;
      if (accept) begin
         if (req_payload.op == ssd_pkg::OP_WRITE) begin
            if (req_payload.position < 3'(ssd_pkg::BufferChars)) begin
               buffer_in[req_payload.position] = req_payload.character;
            end
         end else begin
            if (count == period_ff) begin
               seg_in = light.segments;
               en_in  = light.digit_enable;
            end else if (count == blank_ff) begin
               en_in    = 4'd0;
               index_in = index_ff + 2'd1;
            end
            counter_in = count - 16'd1;
         end
      end
      payload_in.segments     = seg_in;
      payload_in.digit_enable = en_in;
      valid_in = accept | (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff  <= '0;
         counter_ff <= '0;
         index_ff   <= '0;
         seg_ff     <= '0;
         en_ff      <= '0;
         valid_ff   <= 1'b0;
         period_ff  <= ssd_pkg::SCAN_PERIOD_RESET;
         blank_ff   <= ssd_pkg::BLANK_TIME_RESET;
      end else begin
         buffer_ff  <= buffer_in;
         counter_ff <= counter_in;
         index_ff   <= index_in;
         seg_ff     <= seg_in;
         en_ff      <= en_in;
         valid_ff   <= valid_in;
         if (csr_we) begin
            case (csr_index)
               ssd_pkg::CSR_SCAN_PERIOD: period_ff <= csr_wdata;
               ssd_pkg::CSR_BLANK_TIME:  blank_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         payload_ff <= payload_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

// ===== rtl/ssd_checker.sv =====
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks for the seven-segment scan driver, bound to the top.
// ----------------------------------------------------------------------------
module ssd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input ssd_pkg::rsp_payload_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_payload.digit_enable))
      else $error("digit enable not one-hot");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted transaction gave no result");

   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled with free result register");

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/sv/ssd_scan_checker.sv =====
// ----------------------------------------------------------------------------
// ssd_scan_checker
// Watches the request, response and CSR ports of the seven-segment scan
// driver. It keeps its own copy of the text buffer, scan counter and latches,
// predicts the drive for every accepted request transaction and compares
// each accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module ssd_scan_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  ssd_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  ssd_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_we,
   input  logic                     csr_index,
   input  logic [15:0]              csr_wdata,
   output int                       mismatch_count,
   output int                       drives_pending,
   output int                       drives_checked,
   output int                       digits_lit
);
   timeunit 1ns;
   timeprecision 1ps;

   ssd_pkg::char_buffer_type text_store;
   logic [15:0]              tick_count;
   logic [15:0]              period_reg;
   logic [15:0]              blank_reg;
   logic [1:0]               scan_digit;
   logic [7:0]               seg_hold;
   logic [3:0]               en_hold;
   ssd_pkg::rsp_payload_type expected_drive[$];

   function automatic logic [7:0] glyph_pattern(input logic [7:0] code);
      logic [7:0] p;
      case (code)
         ".":     p = ssd_pkg::SEG_POINT;
         "0":     p = 8'h3F;
         "1":     p = 8'h06;
         "2":     p = 8'h5B;
         "3":     p = 8'h4F;
         "4":     p = 8'h66;
         "5":     p = 8'h6D;
         "6":     p = 8'h7D;
         "7":     p = 8'h07;
         "8":     p = 8'h7F;
         "9":     p = 8'h6F;
         "A":     p = 8'h77;
         "C":     p = 8'h39;
         "E":     p = 8'h79;
         "L":     p = 8'h38;
         "O":     p = 8'h3F;
         "a":     p = 8'h5F;
         "b":     p = 8'h7C;
         "c":     p = 8'h58;
         "d":     p = 8'h5E;
         "f":     p = 8'h71;
         "h":     p = 8'h74;
         "n":     p = 8'h54;
         "o":     p = 8'h5C;
         "r":     p = 8'h50;
         "t":     p = 8'h78;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   // first dot in the visible window folds into the point of the digit before it
   function automatic void light_current();
      int         dot_at;
      int         digit;
      int         src;
      logic [7:0] code;
      logic [7:0] seg;
      dot_at = int'(ssd_pkg::Digits);
      for (int i = int'(ssd_pkg::Digits) - 1; i >= 0; i--) begin
         if (text_store[i] == ssd_pkg::DOT_CODE) dot_at = i;
      end
      digit = int'(scan_digit);
      src = (dot_at < int'(ssd_pkg::Digits) && digit >= dot_at) ? digit + 1 : digit;
      code = (src < int'(ssd_pkg::BufferChars)) ? text_store[src] : 8'h00;
      seg = glyph_pattern(code);
      if (dot_at < int'(ssd_pkg::Digits) && dot_at > 0 && digit == dot_at - 1)
         seg |= ssd_pkg::SEG_POINT;
      seg_hold = seg;
      en_hold = 4'b0001 << scan_digit;
      digits_lit++;
   endfunction

   function automatic ssd_pkg::rsp_payload_type advance_scan(
      input ssd_pkg::req_payload_type item);
      ssd_pkg::rsp_payload_type drive;
      if (item.op == ssd_pkg::OP_WRITE) begin
         if (item.position < ssd_pkg::BufferChars)
            text_store[item.position] = item.character;
      end else begin
         if (tick_count == 16'd0) tick_count = period_reg;
         if (tick_count == period_reg) begin
            light_current();
         end else if (tick_count == blank_reg) begin
            en_hold = '0;
            scan_digit = scan_digit + 2'd1;
         end
         tick_count = tick_count - 16'd1;
      end
      drive.segments = seg_hold;
      drive.digit_enable = en_hold;
      return drive;
   endfunction

   always @(posedge clock) begin
      ssd_pkg::rsp_payload_type want;
      if (reset) begin
         text_store = '0;
         tick_count = '0;
         scan_digit = '0;
         seg_hold = '0;
         en_hold = '0;
         period_reg = ssd_pkg::SCAN_PERIOD_RESET;
         blank_reg = ssd_pkg::BLANK_TIME_RESET;
         expected_drive.delete();
         mismatch_count = 0;
         drives_checked = 0;
         digits_lit = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_drive.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected response segments %02h enable %01h", $time,
                           rsp_payload.segments, rsp_payload.digit_enable);
               mismatch_count++;
            end else begin
               want = expected_drive.pop_front();
               drives_checked++;
               if (rsp_payload.segments !== want.segments ||
                   rsp_payload.digit_enable !== want.digit_enable) begin
                  if (mismatch_count < 10)
                     $display("%0t: drive mismatch, expected %02h/%01h, got %02h/%01h",
                              $time, want.segments, want.digit_enable,
                              rsp_payload.segments, rsp_payload.digit_enable);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) expected_drive.push_back(advance_scan(req_payload));
         // register writes take effect after this edge
         if (csr_we) begin
            if (csr_index == ssd_pkg::CSR_SCAN_PERIOD) period_reg = csr_wdata;
            else blank_reg = csr_wdata;
         end
      end
      drives_pending <= expected_drive.size();
   end

endmodule

// ===== tb/sv/tb_seven_segment_scan_driver.sv =====
// ----------------------------------------------------------------------------
// tb_seven_segment_scan_driver
// Stimulus and verdict for the seven-segment scan driver. A directed pass
// covers dot merging, ignored writes and field extremes; random passes follow
// under several scan and blank settings with varying idle and stall pressure,
// including a long response hold-off. Checking lives in ssd_scan_checker.
// ----------------------------------------------------------------------------
module tb_seven_segment_scan_driver;
   timeunit 1ns;
   timeprecision 1ps;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   ssd_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   ssd_pkg::rsp_payload_type rsp_payload;
   logic                     csr_we = 1'b0;
   logic                     csr_index = ssd_pkg::CSR_SCAN_PERIOD;
   logic [15:0]              csr_wdata = '0;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_request = 1'b0;
   logic hold_served = 1'b0;
   int   hold_left = 0;
   int   sent_count = 0;
   int   setting_count = 0;
   int   mismatch_count;
   int   drives_pending;
   int   drives_checked;
   int   digits_lit;

   always #4 clock = ~clock;

   seven_segment_scan_driver DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   ssd_scan_checker scan_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .drives_pending (drives_pending),
      .drives_checked (drives_checked),
      .digits_lit     (digits_lit)
   );

   // response back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_served) begin
         rsp_stall <= 1'b1;
         hold_left <= 300;
         hold_served <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_item(input logic op, input logic [2:0] position,
                            input logic [7:0] character);
      ssd_pkg::req_payload_type item;
      item.op = op;
      item.position = position;
      item.character = character;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic write_setting(input logic index, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_pace(input int idle_pct, input int hold_pct);
      send_idle_pct = idle_pct;
      stall_pct <= hold_pct;
   endtask

   task automatic send_random(input int count, input int tick_pct);
      string      shown;
      int         done;
      logic       op;
      logic [2:0] position;
      logic [7:0] character;
      shown = "0123456789ACELOabcdfhnort";
      done = 0;
      while (done < count) begin
         op = ($urandom_range(99) < tick_pct) ? ssd_pkg::OP_TICK : ssd_pkg::OP_WRITE;
         if ($urandom_range(9) == 0) position = 3'($urandom_range(7, 5));
         else position = 3'($urandom_range(4));
         case ($urandom_range(3))
            0:       character = 8'($urandom);
            1:       character = ssd_pkg::DOT_CODE;
            default: character = shown[$urandom_range(shown.len() - 1)];
         endcase
         send_item(op, position, character);
         if (op == ssd_pkg::OP_TICK || position < ssd_pkg::BufferChars) done++;
      end
   endtask

   task automatic tick_burst(input int count);
      repeat (count) send_item(ssd_pkg::OP_TICK, 3'd0, 8'h00);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fast scan: two ticks per digit
      write_setting(ssd_pkg::CSR_SCAN_PERIOD, 16'd2);
      write_setting(ssd_pkg::CSR_BLANK_TIME, 16'd1);
      send_item(ssd_pkg::OP_WRITE, 3'd7, 8'hFF);
      send_item(ssd_pkg::OP_WRITE, 3'd0, ssd_pkg::DOT_CODE);
      send_item(ssd_pkg::OP_WRITE, 3'd1, "E");
      send_item(ssd_pkg::OP_WRITE, 3'd2, ssd_pkg::DOT_CODE);
      send_item(ssd_pkg::OP_WRITE, 3'd3, 8'hFF);
      send_item(ssd_pkg::OP_WRITE, 3'd4, ssd_pkg::DOT_CODE);
      tick_burst(8);
      send_item(ssd_pkg::OP_WRITE, 3'd0, "5");
      send_item(ssd_pkg::OP_WRITE, 3'd4, 8'h00);
      tick_burst(8);
      drain_results();

      set_pace(8, 86);
      send_random(140, 70);
      drain_results();
      write_setting(ssd_pkg::CSR_SCAN_PERIOD, ssd_pkg::SCAN_PERIOD_RESET);
      write_setting(ssd_pkg::CSR_BLANK_TIME, ssd_pkg::BLANK_TIME_RESET);
      send_random(140, 75);
      drain_results();

      // equal values: lighting wins and the scan stays put
      set_pace(86, 8);
      write_setting(ssd_pkg::CSR_SCAN_PERIOD, 16'd7);
      write_setting(ssd_pkg::CSR_BLANK_TIME, 16'd7);
      send_random(140, 70);
      drain_results();
      write_setting(ssd_pkg::CSR_SCAN_PERIOD, 16'd5);
      write_setting(ssd_pkg::CSR_BLANK_TIME, 16'd9);
      send_random(140, 70);
      drain_results();

      set_pace(0, 0);
      write_setting(ssd_pkg::CSR_SCAN_PERIOD, 16'd3);
      write_setting(ssd_pkg::CSR_BLANK_TIME, 16'd1);
      hold_request <= 1'b1;
      send_random(150, 70);
      drain_results();
      write_setting(ssd_pkg::CSR_SCAN_PERIOD, 16'hFFFF);
      write_setting(ssd_pkg::CSR_BLANK_TIME, 16'hFFFE);
      send_random(60, 70);
      drain_results();

      // zero period: lights once, then the counter wraps to the top
      write_setting(ssd_pkg::CSR_SCAN_PERIOD, 16'd0);
      write_setting(ssd_pkg::CSR_BLANK_TIME, 16'd1);
      send_random(40, 99);
      drain_results();

      $display("Sent %0d request transactions across %0d register writes.",
               sent_count, setting_count);
      $display("Checked %0d responses, %0d digit lightings predicted.",
               drives_checked, digits_lit);
      if (mismatch_count == 0 && drives_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d responses outstanding", drives_pending);
      $display("TEST FAILED");
      $finish;
   end

endmodule
